/* src/uvtcs_pkg.sv */
// Package: shared types, constants and helpers of the uv transform and clip block.
`default_nettype none
package uvtcs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 64;
    localparam int NUM_LANES     = 3;

    localparam logic [2:0] REG_INV_SCALE = 3'd0;
    localparam logic [2:0] REG_SCALE_PIV = 3'd1;
    localparam logic [2:0] REG_ROT_PIV   = 3'd2;
    localparam logic [2:0] REG_COS_SIN   = 3'd3;
    localparam logic [2:0] REG_SHIFT     = 3'd4;
    localparam logic [2:0] REG_U_LIM     = 3'd5;
    localparam logic [2:0] REG_V_LIM     = 3'd6;
    localparam logic [2:0] REG_MODE      = 3'd7;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_S,
        OP_R,
        OP_T
    } t_op;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
    } t_pt;

    // lane 0: coordinate, lane 1: scale pivot, lane 2: rotation pivot
    typedef t_pt [NUM_LANES-1:0] t_lanes;

    typedef struct packed {
        t_lanes      lanes;
        logic [63:0] in_color;
        logic [63:0] out_color;
    } t_item;

    typedef struct packed {
        logic signed [31:0] ku;
        logic signed [31:0] kv;
        logic signed [31:0] tu;
        logic signed [31:0] tv;
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic signed [31:0] umin;
        logic signed [31:0] umax;
        logic signed [31:0] vmin;
        logic signed [31:0] vmax;
        t_pt                spiv;
        t_pt                rpiv;
        logic [3:0]         mode;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // operation at a pipeline position for a given order
    function automatic t_op stage_op(input logic [2:0] order, input logic [1:0] pos);
        t_op r;
        r = OP_NONE;
        case (order)
            3'd0: r = (pos == 2'd0) ? OP_S : (pos == 2'd1) ? OP_R : OP_T;
            3'd1: r = (pos == 2'd0) ? OP_S : (pos == 2'd1) ? OP_T : OP_R;
            3'd2: r = (pos == 2'd0) ? OP_R : (pos == 2'd1) ? OP_S : OP_T;
            3'd3: r = (pos == 2'd0) ? OP_R : (pos == 2'd1) ? OP_T : OP_S;
            3'd4: r = (pos == 2'd0) ? OP_T : (pos == 2'd1) ? OP_S : OP_R;
            3'd5: r = (pos == 2'd0) ? OP_T : (pos == 2'd1) ? OP_R : OP_S;
            default: r = OP_NONE;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/uvtcs_cfg_regs.sv */
// Configuration register file with APB-style write and read port.
`default_nettype none
module uvtcs_cfg_regs #(
    parameter int FRAC_BITS = uvtcs_pkg::FRAC_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_psel,
    input  wire                         i_penable,
    input  wire                         i_pwrite,
    input  wire [uvtcs_pkg::ADDR_W-1:0] i_paddr,
    input  wire [uvtcs_pkg::DATA_W-1:0] i_pwdata,
    output logic [uvtcs_pkg::DATA_W-1:0] o_prdata,
    output logic                        o_pready,
    output uvtcs_pkg::t_cfg             o_cfg
);
    localparam logic [31:0] ONE  = 32'(1) << FRAC_BITS;
    localparam logic [31:0] HALF = ONE >> 1;

    logic [63:0] r_regs [uvtcs_pkg::NUM_REGS-1];
    logic [3:0]  r_mode;
    logic [2:0]  idx;
    logic        wr;

    assign idx      = i_paddr[5:3];
    assign wr       = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[uvtcs_pkg::REG_INV_SCALE] <= {ONE, ONE};
            r_regs[uvtcs_pkg::REG_SCALE_PIV] <= {HALF, HALF};
            r_regs[uvtcs_pkg::REG_ROT_PIV]   <= {HALF, HALF};
            r_regs[uvtcs_pkg::REG_COS_SIN]   <= {ONE, 32'd0};
            r_regs[uvtcs_pkg::REG_SHIFT]     <= 64'd0;
            r_regs[uvtcs_pkg::REG_U_LIM]     <= {32'd0, ONE};
            r_regs[uvtcs_pkg::REG_V_LIM]     <= {32'd0, ONE};
            r_mode                           <= 4'd0;
        end else if (wr) begin
            if (idx == uvtcs_pkg::REG_MODE) begin
                r_mode <= i_pwdata[3:0];
            end else begin
                r_regs[idx] <= i_pwdata;
            end
        end
    end

    always_comb begin
        if (idx == uvtcs_pkg::REG_MODE) begin
            o_prdata = {60'd0, r_mode};
        end else begin
            o_prdata = r_regs[idx];
        end
    end

    always_comb begin
        o_cfg.ku     = r_regs[uvtcs_pkg::REG_INV_SCALE][63:32];
        o_cfg.kv     = r_regs[uvtcs_pkg::REG_INV_SCALE][31:0];
        o_cfg.spiv.u = r_regs[uvtcs_pkg::REG_SCALE_PIV][63:32];
        o_cfg.spiv.v = r_regs[uvtcs_pkg::REG_SCALE_PIV][31:0];
        o_cfg.rpiv.u = r_regs[uvtcs_pkg::REG_ROT_PIV][63:32];
        o_cfg.rpiv.v = r_regs[uvtcs_pkg::REG_ROT_PIV][31:0];
        o_cfg.c      = r_regs[uvtcs_pkg::REG_COS_SIN][63:32];
        o_cfg.s      = r_regs[uvtcs_pkg::REG_COS_SIN][31:0];
        o_cfg.tu     = r_regs[uvtcs_pkg::REG_SHIFT][63:32];
        o_cfg.tv     = r_regs[uvtcs_pkg::REG_SHIFT][31:0];
        o_cfg.umin   = r_regs[uvtcs_pkg::REG_U_LIM][63:32];
        o_cfg.umax   = r_regs[uvtcs_pkg::REG_U_LIM][31:0];
        o_cfg.vmin   = r_regs[uvtcs_pkg::REG_V_LIM][63:32];
        o_cfg.vmax   = r_regs[uvtcs_pkg::REG_V_LIM][31:0];
        o_cfg.mode   = r_mode;
    end
endmodule
`default_nettype wire

/* src/uvtcs_op_stage.sv */
// One transform step (scale, rotate, translate or none) as three pipeline stages.
`default_nettype none
module uvtcs_op_stage #(
    parameter int FRAC_BITS = uvtcs_pkg::FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_adv,
    input  uvtcs_pkg::t_cfg      i_cfg,
    input  uvtcs_pkg::t_op       i_op,
    input  wire                  i_piv,
    input  wire                  i_valid,
    input  uvtcs_pkg::t_item     i_item,
    output logic                 o_valid,
    output uvtcs_pkg::t_item     o_item
);
    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
    localparam int NL = uvtcs_pkg::NUM_LANES;

    // stage A: differences about the pivot
    logic             r_a_valid;
    uvtcs_pkg::t_item r_a_item;
    uvtcs_pkg::t_pt   r_a_base [NL];
    uvtcs_pkg::t_pt   r_a_d    [NL];
    uvtcs_pkg::t_op   r_a_op   [NL];
    uvtcs_pkg::t_pt   n_a_base [NL];
    uvtcs_pkg::t_pt   n_a_d    [NL];
    uvtcs_pkg::t_op   n_a_op   [NL];

    // stage B: products
    logic               r_b_valid;
    uvtcs_pkg::t_item   r_b_item;
    uvtcs_pkg::t_pt     r_b_base [NL];
    logic signed [63:0] r_b_p    [NL][4];
    logic signed [63:0] n_b_p    [NL][4];

    // stage C: round, sum, saturate
    logic             r_c_valid;
    uvtcs_pkg::t_item r_c_item;
    uvtcs_pkg::t_item n_c_item;

    always_comb begin
        uvtcs_pkg::t_pt x;
        uvtcs_pkg::t_pt p;
        for (int l = 0; l < NL; l++) begin
            n_a_op[l] = (l == 0 || i_piv) ? i_op : uvtcs_pkg::OP_NONE;
            x = i_item.lanes[l];
            p = (n_a_op[l] == uvtcs_pkg::OP_S) ? i_item.lanes[1] : i_item.lanes[2];
            case (n_a_op[l])
                uvtcs_pkg::OP_S, uvtcs_pkg::OP_R: begin
                    n_a_base[l] = p;
                    n_a_d[l].u  = uvtcs_pkg::sat32(64'(x.u) - 64'(p.u));
                    n_a_d[l].v  = uvtcs_pkg::sat32(64'(x.v) - 64'(p.v));
                end
                uvtcs_pkg::OP_T: begin
                    n_a_base[l].u = uvtcs_pkg::sat32(64'(x.u) - 64'(i_cfg.tu));
                    n_a_base[l].v = uvtcs_pkg::sat32(64'(x.v) - 64'(i_cfg.tv));
                    n_a_d[l]      = '0;
                end
                default: begin
                    n_a_base[l] = x;
                    n_a_d[l]    = '0;
                end
            endcase
        end
    end

    always_comb begin
        logic signed [31:0] ca, cb, ce, cf;
        for (int l = 0; l < NL; l++) begin
            case (r_a_op[l])
                uvtcs_pkg::OP_S: begin
                    ca = i_cfg.ku; cb = '0; ce = '0; cf = i_cfg.kv;
                end
                uvtcs_pkg::OP_R: begin
                    ca = i_cfg.c; cb = i_cfg.s; ce = i_cfg.s; cf = i_cfg.c;
                end
                default: begin
                    ca = '0; cb = '0; ce = '0; cf = '0;
                end
            endcase
            n_b_p[l][0] = 64'(r_a_d[l].u) * 64'(ca);
            n_b_p[l][1] = 64'(r_a_d[l].v) * 64'(cb);
            n_b_p[l][2] = 64'(r_a_d[l].u) * 64'(ce);
            n_b_p[l][3] = 64'(r_a_d[l].v) * 64'(cf);
        end
    end

    always_comb begin
        logic signed [63:0] m [4];
        n_c_item = r_b_item;
        for (int l = 0; l < NL; l++) begin
            for (int k = 0; k < 4; k++) begin
                m[k] = (r_b_p[l][k] + RND) >>> FRAC_BITS;
            end
            n_c_item.lanes[l].u = uvtcs_pkg::sat32(64'(r_b_base[l].u) + m[0] - m[1]);
            n_c_item.lanes[l].v = uvtcs_pkg::sat32(64'(r_b_base[l].v) + m[2] + m[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_item <= i_item;
            r_a_base <= n_a_base;
            r_a_d    <= n_a_d;
            r_a_op   <= n_a_op;
            r_b_item <= r_a_item;
            r_b_base <= r_a_base;
            r_b_p    <= n_b_p;
            r_c_item <= n_c_item;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c_item;
endmodule
`default_nettype wire

/* src/uvtcs_clip_stage.sv */
// Range test and color selection into the output register.
`default_nettype none
module uvtcs_clip_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_adv,
    input  uvtcs_pkg::t_cfg  i_cfg,
    input  wire              i_valid,
    input  uvtcs_pkg::t_item i_item,
    output logic             o_valid,
    output logic [63:0]      o_color,
    output logic             o_clipped
);
    logic        r_valid;
    logic [63:0] r_color;
    logic        r_clip;
    logic        n_clip;

    always_comb begin
        n_clip = (i_item.lanes[0].u < i_cfg.umin) || (i_item.lanes[0].u > i_cfg.umax) ||
                 (i_item.lanes[0].v < i_cfg.vmin) || (i_item.lanes[0].v > i_cfg.vmax);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_clip  <= n_clip;
            r_color <= n_clip ? i_item.out_color : i_item.in_color;
        end
    end

    assign o_valid   = r_valid;
    assign o_color   = r_color;
    assign o_clipped = r_clip;
endmodule
`default_nettype wire

/* src/uv_transform_clip_select.sv */
// Top level: uv coordinate transform pipeline, range clip and color select.
// Pipeline: three transform steps of three stages each (pivot difference,
//   multiply, round/sum), then the clip register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active low; clears all valid bits and loads register defaults.
`default_nettype none
module uv_transform_clip_select #(
    parameter int FRAC_BITS = uvtcs_pkg::FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] coord_u, [63:32] coord_v, [127:64] inside_color, [191:128] outside_color
    input  wire [191:0] i_s_axis_tdata,
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [63:0] out_color
    output logic [63:0] o_m_axis_tdata,
    // [0] was_clipped
    output logic [0:0]  o_m_axis_tuser,
    // configuration port
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire [uvtcs_pkg::ADDR_W-1:0] i_paddr,
    input  wire [uvtcs_pkg::DATA_W-1:0] i_pwdata,
    output logic [uvtcs_pkg::DATA_W-1:0] o_prdata,
    output logic        o_pready
);
    uvtcs_pkg::t_cfg  cfg;
    uvtcs_pkg::t_item in_item;
    uvtcs_pkg::t_item st_item  [4];
    logic             st_valid [4];
    uvtcs_pkg::t_op   ops      [3];
    logic             adv;

    // single stall enable: everything moves unless a result is held
    assign adv             = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    uvtcs_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_psel   (i_psel),
        .i_penable(i_penable),
        .i_pwrite (i_pwrite),
        .i_paddr  (i_paddr),
        .i_pwdata (i_pwdata),
        .o_prdata (o_prdata),
        .o_pready (o_pready),
        .o_cfg    (cfg)
    );

    // pivots enter as lanes so that earlier steps can move them
    always_comb begin
        in_item.lanes[0].u = i_s_axis_tdata[31:0];
        in_item.lanes[0].v = i_s_axis_tdata[63:32];
        in_item.lanes[1]   = cfg.spiv;
        in_item.lanes[2]   = cfg.rpiv;
        in_item.in_color   = i_s_axis_tdata[127:64];
        in_item.out_color  = i_s_axis_tdata[191:128];
    end

    assign st_item[0]  = in_item;
    assign st_valid[0] = i_s_axis_tvalid;

    for (genvar g = 0; g < 3; g++) begin : g_step
        assign ops[g] = uvtcs_pkg::stage_op(cfg.mode[3:1], 2'(g));
        uvtcs_op_stage #(.FRAC_BITS(FRAC_BITS)) u_op (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_cfg  (cfg),
            .i_op   (ops[g]),
            .i_piv  (cfg.mode[0]),
            .i_valid(st_valid[g]),
            .i_item (st_item[g]),
            .o_valid(st_valid[g+1]),
            .o_item (st_item[g+1])
        );
    end

    uvtcs_clip_stage u_clip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_cfg    (cfg),
        .i_valid  (st_valid[3]),
        .i_item   (st_item[3]),
        .o_valid  (o_m_axis_tvalid),
        .o_color  (o_m_axis_tdata),
        .o_clipped(o_m_axis_tuser[0])
    );

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("held result changed");
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted during stall");
endmodule
`default_nettype wire

/* tb/tb_uv_transform_clip_select.sv */
// Testbench: uv transform and clip block checked against a fixed-point predictor.
`default_nettype none
module tb_uv_transform_clip_select;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int LATENCY = 10;
    localparam int AW = uvtcs_pkg::ADDR_W;

    // register byte addresses, 8 bytes per register
    localparam logic [AW-1:0] A_INV_SCALE = {uvtcs_pkg::REG_INV_SCALE, 3'b000};
    localparam logic [AW-1:0] A_SCALE_PIV = {uvtcs_pkg::REG_SCALE_PIV, 3'b000};
    localparam logic [AW-1:0] A_ROT_PIV   = {uvtcs_pkg::REG_ROT_PIV, 3'b000};
    localparam logic [AW-1:0] A_COS_SIN   = {uvtcs_pkg::REG_COS_SIN, 3'b000};
    localparam logic [AW-1:0] A_SHIFT     = {uvtcs_pkg::REG_SHIFT, 3'b000};
    localparam logic [AW-1:0] A_U_LIM     = {uvtcs_pkg::REG_U_LIM, 3'b000};
    localparam logic [AW-1:0] A_V_LIM     = {uvtcs_pkg::REG_V_LIM, 3'b000};
    localparam logic [AW-1:0] A_MODE      = {uvtcs_pkg::REG_MODE, 3'b000};

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] HALF = 32'h0000_8000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [uvtcs_pkg::DATA_W-1:0] pwdata = '0;
    logic [uvtcs_pkg::DATA_W-1:0] prdata;
    logic         pready;

    always #1 i_clk = ~i_clk;

    uv_transform_clip_select dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    // shadow copy of the register file
    logic [63:0] shadow [uvtcs_pkg::NUM_REGS];

    typedef struct packed {
        logic [63:0] color;
        logic        clipped;
    } t_color_res;

    t_color_res color_fifo[$];
    int errors = 0;
    int n_sent = 0, n_recv = 0, n_clipped = 0;
    bit long_hold = 1'b0;

    function automatic logic signed [63:0] hi32(input logic [63:0] r);
        return {{32{r[63]}}, r[63:32]};
    endfunction

    function automatic logic signed [63:0] lo32(input logic [63:0] r);
        return {{32{r[31]}}, r[31:0]};
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // round half up then arithmetic shift (floor)
    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return (p + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic void scale_about(input logic signed [63:0] pu, pv, ku, kv,
                                        inout logic signed [63:0] u, v);
        u = clamp32(pu + qmul(clamp32(u - pu), ku));
        v = clamp32(pv + qmul(clamp32(v - pv), kv));
    endfunction

    function automatic void rotate_about(input logic signed [63:0] pu, pv, c, s,
                                         inout logic signed [63:0] u, v);
        logic signed [63:0] du, dv;
        du = clamp32(u - pu);
        dv = clamp32(v - pv);
        u = clamp32(pu + qmul(du, c) - qmul(dv, s));
        v = clamp32(pv + qmul(du, s) + qmul(dv, c));
    endfunction

    function automatic void translate(input logic signed [63:0] tu, tv,
                                      inout logic signed [63:0] u, v);
        u = clamp32(u - tu);
        v = clamp32(v - tv);
    endfunction

    function automatic t_color_res predict_color(input logic [191:0] d);
        logic signed [63:0] u, v, ku, kv, su, sv, ru, rv, c, s, tu, tv;
        logic [3:0] mode;
        logic piv, clip;
        t_color_res r;
        u = lo32(d[31:0]);  v = lo32(d[63:32]);
        ku = hi32(shadow[uvtcs_pkg::REG_INV_SCALE]); kv = lo32(shadow[uvtcs_pkg::REG_INV_SCALE]);
        su = hi32(shadow[uvtcs_pkg::REG_SCALE_PIV]); sv = lo32(shadow[uvtcs_pkg::REG_SCALE_PIV]);
        ru = hi32(shadow[uvtcs_pkg::REG_ROT_PIV]);   rv = lo32(shadow[uvtcs_pkg::REG_ROT_PIV]);
        c  = hi32(shadow[uvtcs_pkg::REG_COS_SIN]);   s  = lo32(shadow[uvtcs_pkg::REG_COS_SIN]);
        tu = hi32(shadow[uvtcs_pkg::REG_SHIFT]);     tv = lo32(shadow[uvtcs_pkg::REG_SHIFT]);
        mode = shadow[uvtcs_pkg::REG_MODE][3:0];
        piv = mode[0];
        case (mode[3:1])
            3'd0: begin
                scale_about(su, sv, ku, kv, u, v);
                if (piv) scale_about(su, sv, ku, kv, ru, rv);
                rotate_about(ru, rv, c, s, u, v);
                translate(tu, tv, u, v);
            end
            3'd1: begin
                scale_about(su, sv, ku, kv, u, v);
                if (piv) scale_about(su, sv, ku, kv, ru, rv);
                translate(tu, tv, u, v);
                if (piv) translate(tu, tv, ru, rv);
                rotate_about(ru, rv, c, s, u, v);
            end
            3'd2: begin
                rotate_about(ru, rv, c, s, u, v);
                if (piv) rotate_about(ru, rv, c, s, su, sv);
                scale_about(su, sv, ku, kv, u, v);
                translate(tu, tv, u, v);
            end
            3'd3: begin
                rotate_about(ru, rv, c, s, u, v);
                if (piv) rotate_about(ru, rv, c, s, su, sv);
                translate(tu, tv, u, v);
                if (piv) translate(tu, tv, su, sv);
                scale_about(su, sv, ku, kv, u, v);
            end
            3'd4: begin
                translate(tu, tv, u, v);
                if (piv) begin
                    translate(tu, tv, su, sv);
                    translate(tu, tv, ru, rv);
                end
                scale_about(su, sv, ku, kv, u, v);
                if (piv) scale_about(su, sv, ku, kv, ru, rv);
                rotate_about(ru, rv, c, s, u, v);
            end
            3'd5: begin
                translate(tu, tv, u, v);
                if (piv) begin
                    translate(tu, tv, su, sv);
                    translate(tu, tv, ru, rv);
                end
                rotate_about(ru, rv, c, s, u, v);
                if (piv) rotate_about(ru, rv, c, s, su, sv);
                scale_about(su, sv, ku, kv, u, v);
            end
            default: ; // undefined order: coordinate passes untouched
        endcase
        clip = (u < hi32(shadow[uvtcs_pkg::REG_U_LIM])) ||
               (u > lo32(shadow[uvtcs_pkg::REG_U_LIM])) ||
               (v < hi32(shadow[uvtcs_pkg::REG_V_LIM])) ||
               (v > lo32(shadow[uvtcs_pkg::REG_V_LIM]));
        r.color = clip ? d[191:128] : d[127:64];
        r.clipped = clip;
        return r;
    endfunction

    // APB write: setup then access, register taken when pready is high
    task automatic reg_write(input logic [AW-1:0] addr, input logic [63:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = val; penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr[AW-1:3] < uvtcs_pkg::NUM_REGS)
            shadow[addr[AW-1:3]] = (addr[AW-1:3] == uvtcs_pkg::REG_MODE) ?
                                   (val & 64'hF) : val;
    endtask

    // block must be drained before touching configuration
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (color_fifo.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // one request: random gap, then hold tvalid until accepted
    task automatic send_request(input logic [191:0] d, input bit has_exp,
                                input t_color_res exp_res);
        t_color_res r;
        repeat ($urandom_range(0, 6)) @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata = d;
        do @(posedge i_clk); while (!s_tready);
        r = predict_color(d);
        if (has_exp && r != exp_res) begin
            $error("table row disagrees with predictor: %h vs %h", exp_res, r);
            errors++;
        end
        color_fifo.push_back(has_exp ? exp_res : r);
        n_sent++;
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_tready = 1'b0;
                repeat (60) @(negedge i_clk);
                long_hold = 1'b0;
            end
            m_tready = ($urandom_range(0, 6) < 4) || (n_sent % 97 > 80);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_color_res e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (color_fifo.size() == 0) begin
                $error("result with nothing expected: color %h", m_tdata);
                errors++;
            end else begin
                e = color_fifo.pop_front();
                if (m_tdata !== e.color) begin
                    $error("out_color expected %h actual %h", e.color, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== e.clipped) begin
                    $error("was_clipped expected %0b actual %0b", e.clipped, m_tuser[0]);
                    errors++;
                end
                n_recv++;
                if (m_tuser[0]) n_clipped++;
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_uv_transform_clip_select NOT OK");
        $finish;
    end

    // directed table: coordinate pair and expected clip result; colors are drawn at random
    typedef struct {
        logic [31:0] u;
        logic [31:0] v;
        bit          known;
        bit          clip;
    } t_row;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            2: return 32'h8000_0000 | ($urandom & 32'h0000_00FF);
            3: return 32'h7FFF_FF00 | ($urandom & 32'h0000_00FF);
            default: return 32'($urandom_range(0, 32'h0001_8000)) - 32'h0000_4000;
        endcase
    endfunction

    // mostly usable settings, sometimes extremes
    function automatic logic [31:0] rnd_q(input int span);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    task automatic random_config();
        reg_write(A_INV_SCALE, {rnd_q(3 * 65536), rnd_q(3 * 65536)});
        reg_write(A_SCALE_PIV, {rnd_q(65536), rnd_q(65536)});
        reg_write(A_ROT_PIV, {rnd_q(65536), rnd_q(65536)});
        reg_write(A_COS_SIN, {rnd_q(65536), rnd_q(65536)});
        reg_write(A_SHIFT, {rnd_q(32768), rnd_q(32768)});
        reg_write(A_U_LIM, {rnd_q(16384), 32'(65536 - 16384) + rnd_q(16384)});
        reg_write(A_V_LIM, {rnd_q(16384), 32'(65536 - 16384) + rnd_q(16384)});
        reg_write(A_MODE, 64'($urandom_range(0, 15)) | (64'($urandom) << 4));
    endtask

    initial begin
        t_row rows[$];
        t_color_res er;
        logic [191:0] d;
        shadow[uvtcs_pkg::REG_INV_SCALE] = {ONE, ONE};
        shadow[uvtcs_pkg::REG_SCALE_PIV] = {HALF, HALF};
        shadow[uvtcs_pkg::REG_ROT_PIV]   = {HALF, HALF};
        shadow[uvtcs_pkg::REG_COS_SIN]   = {ONE, 32'h0};
        shadow[uvtcs_pkg::REG_SHIFT]     = '0;
        shadow[uvtcs_pkg::REG_U_LIM]     = {32'h0, ONE};
        shadow[uvtcs_pkg::REG_V_LIM]     = {32'h0, ONE};
        shadow[uvtcs_pkg::REG_MODE]      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings are identity: clip reads straight off the limits
        rows = '{
            '{32'h0000_0000, 32'h0000_0000, 1, 0},
            '{ONE,           ONE,           1, 0},
            '{HALF,          HALF,          1, 0},
            '{32'hFFFF_FFFF, HALF,          1, 1},
            '{HALF,          32'h0001_0001, 1, 1},
            '{32'h8000_0000, 32'h8000_0000, 1, 1},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1},
            '{32'h7FFF_FFFF, 32'h8000_0000, 1, 1}
        };
        foreach (rows[i]) begin
            er.color = 64'h0;
            d = {rnd64(), rnd64(), rows[i].v, rows[i].u};
            er.clipped = rows[i].clip;
            er.color = rows[i].clip ? d[191:128] : d[127:64];
            send_request(d, 1'b1, er);
        end
        wait_drained();

        // every mode with a rotation, scale and shift, pivot flag both ways
        reg_write(A_INV_SCALE, {32'h0002_0000, 32'hFFFF_8000});
        reg_write(A_COS_SIN, {32'h0000_B505, 32'hFFFF_4AFB});
        reg_write(A_SHIFT, {32'h0000_2000, 32'hFFFF_E000});
        reg_write(A_SCALE_PIV, {32'h0000_4000, 32'h0000_C000});
        for (int m = 0; m < 16; m++) begin
            reg_write(A_MODE, 64'(m));
            send_request({rnd64(), rnd64(), 32'h0000_6000, 32'h0000_A000}, 1'b0, er);
            wait_drained();
        end
        // empty ranges: every item clipped; zero scale with extreme coordinates
        reg_write(A_U_LIM, {ONE, 32'h0});
        reg_write(A_INV_SCALE, 64'h0);
        reg_write(A_MODE, 64'h0);
        d = {rnd64(), rnd64(), 32'h8000_0000, 32'h7FFF_FFFF};
        er.clipped = 1'b1; er.color = d[191:128];
        send_request(d, 1'b1, er);
        wait_drained();
        reg_write(A_INV_SCALE, {32'h7FFF_FFFF, 32'h8000_0000});
        reg_write(A_U_LIM, {32'h8000_0000, 32'h7FFF_FFFF});
        reg_write(A_V_LIM, {32'h8000_0000, 32'h7FFF_FFFF});
        send_request({rnd64(), rnd64(), 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, er);
        send_request({rnd64(), rnd64(), 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, er);
        wait_drained();

        // random phases, new settings between them
        for (int ph = 0; ph < 10; ph++) begin
            random_config();
            if (ph == 3) long_hold = 1'b1;
            for (int k = 0; k < 80; k++) begin
                if (ph == 3) begin
                    // back-to-back requests while the receiver is held off
                    @(negedge i_clk);
                    s_tvalid = 1'b1;
                    s_tdata = {rnd64(), rnd64(), rnd_coord(), rnd_coord()};
                    do @(posedge i_clk); while (!s_tready);
                    color_fifo.push_back(predict_color(s_tdata));
                    n_sent++;
                    if (k == 79) begin
                        @(negedge i_clk);
                        s_tvalid = 1'b0;
                    end
                end else begin
                    send_request({rnd64(), rnd64(), rnd_coord(), rnd_coord()}, 1'b0, er);
                end
            end
            wait_drained();
        end

        $display("sent %0d requests over all 16 mode codes and 10 random settings", n_sent);
        $display("received %0d results, %0d of them clipped", n_recv, n_clipped);
        if (errors == 0 && color_fifo.size() == 0) begin
            $display("tb_uv_transform_clip_select OK");
        end else begin
            $display("tb_uv_transform_clip_select NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
